[design/assert_macros.svh]
// Assertion macros used by the translator back end (pat_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pat_pkg.sv]
// Types, constants and codes shared by the paged address translator.
`timescale 1ns / 1ps

package pat_pkg;

    localparam int ADDR_WIDTH   = 20;
    localparam int PHYS_WIDTH   = 15;
    localparam int VPAGE_WIDTH  = 4;
    localparam int COUNT_WIDTH  = 32;
    localparam int MASK_WIDTH   = 16;
    localparam int MASK_IDX_W   = $clog2(MASK_WIDTH);
    localparam int STATUS_WIDTH = 3;
    localparam int QUEUE_DEPTH  = 2;

    localparam int DEF_PAGE_COUNT   = 16;
    localparam int DEF_FRAME_COUNT  = 8;
    localparam int DEF_OFFSET_WIDTH = 12;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_HIT   = 3'd0,
        ST_FREE  = 3'd1,
        ST_EVICT = 3'd2,
        ST_RANGE = 3'd3,
        ST_PROT  = 3'd4
    } pat_status_t;

    typedef enum logic [1:0] {
        CLS_ACCESS,
        CLS_RANGE,
        CLS_PROT
    } pat_class_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_HIT_RD,
        S_SWEEP,
        S_VICT_RD,
        S_EVICT,
        S_LOAD,
        S_REPORT
    } pat_state_t;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] logical_address;
        logic                  is_write;
    } pat_request_t;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0] status;
        logic [PHYS_WIDTH-1:0]   physical_address;
        logic [VPAGE_WIDTH-1:0]  victim_page;
        logic                    victim_dirty;
        logic [COUNT_WIDTH-1:0]  access_count;
        logic [COUNT_WIDTH-1:0]  fault_count;
        logic [COUNT_WIDTH-1:0]  hit_count;
    } pat_result_t;

    // One classified access word as it waits between front and back.
    typedef struct packed {
        pat_class_t            cls;
        logic [ADDR_WIDTH-1:0] logical_address;
        logic                  is_write;
    } pat_job_t;

    typedef struct packed {
        logic     push;
        pat_job_t word;
    } pat_push_t;

endpackage

[design/pat_front.sv]
// Front end: takes accesses, holds the read-only mask, flags range and protection errors.
`timescale 1ns / 1ps

module pat_front #(
    parameter int PAGE_COUNT   = pat_pkg::DEF_PAGE_COUNT,
    parameter int OFFSET_WIDTH = pat_pkg::DEF_OFFSET_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  pat_pkg::pat_request_t               request,
    input  logic                                cfg_write,
    input  logic [pat_pkg::MASK_WIDTH-1:0]      cfg_data,
    output pat_pkg::pat_push_t                  enq
);
    import pat_pkg::*;

    logic [MASK_WIDTH-1:0] read_only_mask_reg;
    logic [31:0]           page_full;
    logic                  out_of_range;
    logic                  protected_page;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_only_mask_reg <= '0;
        end
        else if (cfg_write)
        begin
            read_only_mask_reg <= cfg_data;
        end
    end

    assign page_full    = 32'(request.logical_address) >> OFFSET_WIDTH;
    assign out_of_range = page_full >= 32'(PAGE_COUNT);
    // Pages past the mask are always writable.
    assign protected_page = request.is_write && (page_full < 32'(MASK_WIDTH))
                            && read_only_mask_reg[page_full[MASK_IDX_W-1:0]];

    always_comb
    begin
        enq.push                 = start && !busy;
        enq.word.logical_address = request.logical_address;
        enq.word.is_write        = request.is_write;
        priority if (out_of_range)
        begin
            enq.word.cls = CLS_RANGE;
        end
        else if (protected_page)
        begin
            enq.word.cls = CLS_PROT;
        end
        else
        begin
            enq.word.cls = CLS_ACCESS;
        end
    end

endmodule

[design/pat_queue.sv]
// Short queue of classified words between front and back.
`timescale 1ns / 1ps

module pat_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  pat_pkg::pat_push_t enq,
    input  logic               pop,
    output logic               not_empty,
    output logic               full,
    output pat_pkg::pat_job_t  head
);
    import pat_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

    pat_job_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign not_empty = count_reg != '0;
    assign full      = count_reg == DEPTH_CNT;
    assign do_push   = enq.push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= enq.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[design/pat_back.sv]
// Back end: page table, frame fill, second-chance sweep, counters and result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pat_back #(
    parameter int PAGE_COUNT   = pat_pkg::DEF_PAGE_COUNT,
    parameter int FRAME_COUNT  = pat_pkg::DEF_FRAME_COUNT,
    parameter int OFFSET_WIDTH = pat_pkg::DEF_OFFSET_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  pat_pkg::pat_job_t    job_word,
    output logic                 job_pop,
    output pat_pkg::pat_result_t result,
    output logic                 done
);
    import pat_pkg::*;

    localparam int PIW = $clog2(PAGE_COUNT);
    localparam int FW  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int UW  = $clog2(FRAME_COUNT + 1);
    localparam logic [UW-1:0]  FRAME_FULL = UW'(FRAME_COUNT);
    localparam logic [PIW-1:0] LAST_PAGE  = PIW'(PAGE_COUNT - 1);
    localparam logic [31:0]    OFS_MASK   = (32'd1 << OFFSET_WIDTH) - 32'd1;

    pat_state_t             state_reg;
    pat_state_t             state_next;
    pat_job_t               job_reg;
    logic [PAGE_COUNT-1:0]  present_reg;
    logic [PAGE_COUNT-1:0]  ref_reg;
    logic [PAGE_COUNT-1:0]  dirty_reg;
    logic [UW-1:0]          frames_used_reg;
    logic [COUNT_WIDTH-1:0] acc_reg;
    logic [COUNT_WIDTH-1:0] flt_reg;
    logic [COUNT_WIDTH-1:0] hit_reg;
    logic                   done_reg;
    pat_result_t            result_reg;
    pat_status_t            status_reg;
    logic [FW-1:0]          frame_reg;
    logic [PIW-1:0]         victim_reg;
    logic                   vdirty_reg;
    logic [PIW-1:0]         sweep_idx_reg;
    logic                   first_found_reg;
    logic [PIW-1:0]         first_idx_reg;
    logic [FW-1:0]          frame_mem [PAGE_COUNT];
    logic [FW-1:0]          rdata_reg;
    logic [PIW-1:0]         rd_addr;

    logic [31:0]            page_full;
    logic [PIW-1:0]         page_idx;
    logic [31:0]            offset;
    logic [31:0]            phys_full;
    logic                   pg_present;
    logic                   frames_full;
    logic                   cur_present;
    logic                   cur_ref;
    logic                   sweep_take;
    logic                   sweep_end;
    logic [PIW-1:0]         sweep_victim;
    logic                   is_fault;
    logic [COUNT_WIDTH-1:0] acc_next;
    logic [COUNT_WIDTH-1:0] flt_next;
    logic [COUNT_WIDTH-1:0] hit_next;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    assign page_full   = 32'(job_reg.logical_address) >> OFFSET_WIDTH;
    assign page_idx    = page_full[PIW-1:0];
    assign offset      = 32'(job_reg.logical_address) & OFS_MASK;
    assign phys_full   = (32'(frame_reg) << OFFSET_WIDTH) | offset;
    assign pg_present  = present_reg[page_idx];
    assign frames_full = frames_used_reg == FRAME_FULL;

    assign cur_present = present_reg[sweep_idx_reg];
    assign cur_ref     = ref_reg[sweep_idx_reg];
    assign sweep_take  = cur_present && !cur_ref;
    assign sweep_end   = sweep_idx_reg == LAST_PAGE;

    // With every present page referenced, fall back to the first present one.
    always_comb
    begin
        priority if (sweep_take)
        begin
            sweep_victim = sweep_idx_reg;
        end
        else if (first_found_reg)
        begin
            sweep_victim = first_idx_reg;
        end
        else
        begin
            sweep_victim = sweep_idx_reg;
        end
    end

    assign is_fault = (status_reg == ST_FREE) || (status_reg == ST_EVICT);
    assign acc_next = sat_inc(acc_reg);
    assign flt_next = is_fault ? sat_inc(flt_reg) : flt_reg;
    assign hit_next = (status_reg == ST_HIT) ? sat_inc(hit_reg) : hit_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                priority if (job_reg.cls != CLS_ACCESS)
                begin
                    state_next = S_REPORT;
                end
                else if (pg_present)
                begin
                    state_next = S_HIT_RD;
                end
                else if (!frames_full)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_SWEEP;
                end
            end
            S_HIT_RD:  state_next = S_REPORT;
            S_SWEEP:
            begin
                if (sweep_take || sweep_end)
                begin
                    state_next = S_VICT_RD;
                end
            end
            S_VICT_RD: state_next = S_EVICT;
            S_EVICT:   state_next = S_LOAD;
            S_LOAD:    state_next = S_REPORT;
            S_REPORT:  state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop = 1'b0;
        rd_addr = page_idx;
        unique case (state_reg)
            S_IDLE:    job_pop = job_valid;
            S_VICT_RD: rd_addr = victim_reg;
            default:   job_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            present_reg     <= '0;
            ref_reg         <= '0;
            dirty_reg       <= '0;
            frames_used_reg <= '0;
            acc_reg         <= '0;
            flt_reg         <= '0;
            hit_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == S_REPORT;
            unique case (state_reg)
                S_LOOKUP:
                begin
                    if (job_reg.cls == CLS_ACCESS && !pg_present && !frames_full)
                    begin
                        frames_used_reg <= frames_used_reg + 1'b1;
                    end
                end
                S_HIT_RD:
                begin
                    ref_reg[page_idx] <= 1'b1;
                    if (job_reg.is_write)
                    begin
                        dirty_reg[page_idx] <= 1'b1;
                    end
                end
                S_SWEEP:
                begin
                    // Second chance: drop the reference bit and move on.
                    if (cur_present && cur_ref)
                    begin
                        ref_reg[sweep_idx_reg] <= 1'b0;
                    end
                end
                S_EVICT:
                begin
                    present_reg[victim_reg] <= 1'b0;
                    ref_reg[victim_reg]     <= 1'b0;
                    dirty_reg[victim_reg]   <= 1'b0;
                end
                S_LOAD:
                begin
                    present_reg[page_idx] <= 1'b1;
                    ref_reg[page_idx]     <= 1'b1;
                    dirty_reg[page_idx]   <= job_reg.is_write;
                end
                S_REPORT:
                begin
                    acc_reg <= acc_next;
                    flt_reg <= flt_next;
                    hit_reg <= hit_next;
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= frame_mem[rd_addr];
        if (state_reg == S_LOAD)
        begin
            frame_mem[page_idx] <= frame_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_reg <= job_word;
                end
            end
            S_LOOKUP:
            begin
                victim_reg      <= '0;
                vdirty_reg      <= 1'b0;
                sweep_idx_reg   <= '0;
                first_found_reg <= 1'b0;
                first_idx_reg   <= '0;
                frame_reg       <= frames_used_reg[FW-1:0];
                priority if (job_reg.cls == CLS_RANGE)
                begin
                    status_reg <= ST_RANGE;
                end
                else if (job_reg.cls == CLS_PROT)
                begin
                    status_reg <= ST_PROT;
                end
                else if (pg_present)
                begin
                    status_reg <= ST_HIT;
                end
                else if (!frames_full)
                begin
                    status_reg <= ST_FREE;
                end
                else
                begin
                    status_reg <= ST_EVICT;
                end
            end
            S_HIT_RD:
            begin
                frame_reg <= rdata_reg;
            end
            S_SWEEP:
            begin
                sweep_idx_reg <= sweep_idx_reg + 1'b1;
                victim_reg    <= sweep_victim;
                if (cur_present && !first_found_reg)
                begin
                    first_found_reg <= 1'b1;
                    first_idx_reg   <= sweep_idx_reg;
                end
            end
            S_EVICT:
            begin
                frame_reg  <= rdata_reg;
                vdirty_reg <= dirty_reg[victim_reg];
            end
            S_REPORT:
            begin
                result_reg.status           <= status_reg;
                result_reg.victim_page      <= VPAGE_WIDTH'(victim_reg);
                result_reg.victim_dirty     <= vdirty_reg;
                result_reg.access_count     <= acc_next;
                result_reg.fault_count      <= flt_next;
                result_reg.hit_count        <= hit_next;
                if (status_reg == ST_RANGE || status_reg == ST_PROT)
                begin
                    result_reg.physical_address <= '0;
                end
                else
                begin
                    result_reg.physical_address <= phys_full[PHYS_WIDTH-1:0];
                end
            end
            default:
            begin
                frame_reg <= frame_reg;
            end
        endcase
    end

    assign result = result_reg;
    assign done   = done_reg;

    `PAT_ASSERT_NEXT(a_done_single, done_reg, !done_reg, "result strobe held longer than one cycle")
    `PAT_ASSERT_NOW(a_fill_bound, 1'b1, frames_used_reg <= FRAME_FULL, "frame fill count overran")
    `PAT_ASSERT_NOW(a_sweep_full, state_reg == S_SWEEP, frames_full, "sweep started with a free frame")
    `PAT_ASSERT_NOW(a_victim_present, state_reg == S_EVICT, present_reg[victim_reg],
                    "eviction picked a page that is not present")

endmodule

[design/paged_address_translator.sv]
// Top level of the paged address translator.
`timescale 1ns / 1ps

// Paged address translator. Raise start with a request word while busy is low; the word is
// taken at that edge and queued (two words deep), and busy rises only when the queue is full.
// Each word yields exactly one result word, shown on result for one cycle with done high; the
// receiver cannot hold it off, so sample it on that cycle. Results leave in request order.
// The back end handles one word at a time: range and protection errors pass lookup, report;
// hits lookup, frame read, report; faults into a free frame lookup, load, report; faults with
// no free frame lookup, a second-chance sweep of 1 to PAGE_COUNT page entries (one entry per
// cycle), victim read, eviction, load, report. Frames fill in order and are tracked by a fill
// count; the page table resets with no clearing pass. Write read_only_mask only while idle.
module paged_address_translator #(
    parameter int PAGE_COUNT   = pat_pkg::DEF_PAGE_COUNT,
    parameter int FRAME_COUNT  = pat_pkg::DEF_FRAME_COUNT,
    parameter int OFFSET_WIDTH = pat_pkg::DEF_OFFSET_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pat_pkg::pat_request_t          request,
    input  logic                           cfg_write,
    input  logic [pat_pkg::MASK_WIDTH-1:0] cfg_data,
    output pat_pkg::pat_result_t           result,
    output logic                           done
);
    import pat_pkg::*;

    pat_push_t enq;
    pat_job_t  head;
    logic      not_empty;
    logic      full;
    logic      pop;

    assign busy = full;

    pat_front #(
        .PAGE_COUNT   (PAGE_COUNT),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (full),
        .request   (request),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .enq       (enq)
    );

    pat_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq       (enq),
        .pop       (pop),
        .not_empty (not_empty),
        .full      (full),
        .head      (head)
    );

    pat_back #(
        .PAGE_COUNT   (PAGE_COUNT),
        .FRAME_COUNT  (FRAME_COUNT),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (not_empty),
        .job_word  (head),
        .job_pop   (pop),
        .result    (result),
        .done      (done)
    );

endmodule
